>>> hw/rtl/camera_point_projector_macros.svh
// ----------------------------------------------------------------------------
// camera point projector assertion macros
// shared assertion forms for the checker of the projector
// ----------------------------------------------------------------------------
`ifndef CAMERA_POINT_PROJECTOR_MACROS_SVH
`define CAMERA_POINT_PROJECTOR_MACROS_SVH

// checked at every edge, reset included
`define CPP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("projector check failed");

// checked outside reset
`define CPP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("projector check failed");

`endif

>>> hw/rtl/cpp_pkg.sv
// ----------------------------------------------------------------------------
// camera point projector package
// widths, fixed constants, register indexes, shared types and helpers
// ----------------------------------------------------------------------------
`default_nettype none

package cpp_pkg;

   localparam int COORD_W  = 24;
   localparam int TRIG_W   = 14;
   localparam int PIXEL_W  = 16;
   localparam int DEPTH_W  = 16;

   localparam int FIXED_SCALE   = 4096;
   localparam int SCALE_SHIFT   = $clog2(FIXED_SCALE);
   localparam int FOCAL         = 256;
   localparam int SCREEN_WIDTH  = 320;
   localparam int SCREEN_HEIGHT = 240;
   localparam int HALF_WIDTH    = SCREEN_WIDTH / 2;
   localparam int HALF_HEIGHT   = SCREEN_HEIGHT / 2;
   localparam int NEAR_DEPTH    = 16;
   localparam int FAR_DEPTH     = 65535;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_CAM_X       = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAM_Y       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAM_Z       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIN_NEG_YAW = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COS_NEG_YAW = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIN_PITCH   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_COS_PITCH   = 3'd6;

   localparam logic signed [TRIG_W-1:0] TRIG_ONE = 14'sd4096;

   // divider: numerator magnitude bits, quotient bits per stage
   localparam int NUM_W      = 40;
   localparam int DIV_STEP   = 4;
   localparam int DIV_STAGES = NUM_W / DIV_STEP;
   localparam int DIV_LAT    = DIV_STAGES + 2;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic                      visible;
      logic signed [NUM_W-1:0]   num_x;
      logic signed [NUM_W-1:0]   num_y;
      logic        [DEPTH_W-1:0] depth;
   } cpp_item_type;

   typedef struct packed {
      logic                       visible;
      logic signed [PIXEL_W-1:0]  screen_x;
      logic signed [PIXEL_W-1:0]  screen_y;
      logic        [DEPTH_W-1:0]  depth;
   } cpp_result_type;

   // divide by the fixed scale, truncating toward zero
   function automatic logic signed [43:0] scale_down(input logic signed [43:0] v);
      logic signed [43:0] bias;
      bias = v[43] ? 44'(FIXED_SCALE - 1) : 44'sd0;
      return (v + bias) >>> SCALE_SHIFT;
   endfunction

   function automatic logic signed [PIXEL_W-1:0] sat16(input logic signed [41:0] v);
      logic signed [PIXEL_W-1:0] r;
      if (v > 42'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -42'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[PIXEL_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cpp_fifo.sv
// ----------------------------------------------------------------------------
// cpp fifo
// small first-in first-out queue held in flip-flops
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == (AW+1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      // pointers wrap at the last entry
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : AW'(rd_ptr_ff + 1'b1);
      end
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/cpp_front.sv
// ----------------------------------------------------------------------------
// cpp front
// camera registers, translation, yaw and pitch rotation, depth clipping
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   output logic                                   full,
   input  logic signed [cpp_pkg::COORD_W-1:0]     req_point_x,
   input  logic signed [cpp_pkg::COORD_W-1:0]     req_point_y,
   input  logic signed [cpp_pkg::COORD_W-1:0]     req_point_z,
   input  logic                                   csr_we,
   input  logic        [cpp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [cpp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                                   q_push,
   output cpp_pkg::cpp_item_type                  q_item,
   input  logic                                   q_full
);
   import cpp_pkg::*;

   logic signed [COORD_W-1:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic signed [TRIG_W-1:0]  sny_ff, cny_ff, sp_ff, cp_ff;

   logic [5:0] valid_ff, valid_in;
   logic       en;

   // stage 1
   logic signed [COORD_W:0] rx_ff, ry_ff, rz_ff, rx_in, ry_in, rz_in;
   // stage 2
   logic signed [38:0] pxc_ff, pzs_ff, pzc_ff, pxs_ff, ryc2_ff, rys2_ff;
   logic signed [38:0] pxc_in, pzs_in, pzc_in, pxs_in, ryc2_in, rys2_in;
   // stage 3
   logic signed [43:0] x1_wide, z1_wide;
   logic signed [27:0] x1_3_ff, z1_ff, x1_3_in, z1_in;
   logic signed [38:0] ryc3_ff, rys3_ff;
   // stage 4
   logic signed [41:0] z1s_ff, z1c_ff, z1s_in, z1c_in;
   logic signed [27:0] x1_4_ff;
   logic signed [38:0] ryc4_ff, rys4_ff;
   // stage 5
   logic signed [43:0] y2_wide, z2_wide;
   logic signed [30:0] y2_ff, z2_ff, y2_in, z2_in;
   logic signed [27:0] x1_5_ff;
   // stage 6
   cpp_item_type item_ff, item_in;
   logic         vis;

   always_ff @(posedge clock) begin
      if (reset) begin
         cam_x_ff <= '0;
         cam_y_ff <= '0;
         cam_z_ff <= '0;
         sny_ff   <= '0;
         cny_ff   <= TRIG_ONE;
         sp_ff    <= '0;
         cp_ff    <= TRIG_ONE;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CAM_X:       cam_x_ff <= csr_wdata[COORD_W-1:0];
            CSR_CAM_Y:       cam_y_ff <= csr_wdata[COORD_W-1:0];
            CSR_CAM_Z:       cam_z_ff <= csr_wdata[COORD_W-1:0];
            CSR_SIN_NEG_YAW: sny_ff   <= csr_wdata[TRIG_W-1:0];
            CSR_COS_NEG_YAW: cny_ff   <= csr_wdata[TRIG_W-1:0];
            CSR_SIN_PITCH:   sp_ff    <= csr_wdata[TRIG_W-1:0];
            CSR_COS_PITCH:   cp_ff    <= csr_wdata[TRIG_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipe stalls only when its last stage cannot enter the queue
   assign en       = !(valid_ff[5] && q_full);
   assign full     = !en;
   assign q_push   = valid_ff[5] && !q_full;
   assign q_item   = item_ff;
   assign valid_in = {valid_ff[4:0], push && en};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      rx_in   = (COORD_W+1)'(req_point_x) - (COORD_W+1)'(cam_x_ff);
      ry_in   = (COORD_W+1)'(req_point_y) - (COORD_W+1)'(cam_y_ff);
      rz_in   = (COORD_W+1)'(req_point_z) - (COORD_W+1)'(cam_z_ff);
      pxc_in  = 39'(rx_ff) * 39'(cny_ff);
      pzs_in  = 39'(rz_ff) * 39'(sny_ff);
      pzc_in  = 39'(rz_ff) * 39'(cny_ff);
      pxs_in  = 39'(rx_ff) * 39'(sny_ff);
      ryc2_in = 39'(ry_ff) * 39'(cp_ff);
      rys2_in = 39'(ry_ff) * 39'(sp_ff);
      x1_wide = scale_down(44'(pxc_ff) + 44'(pzs_ff));
      z1_wide = scale_down(44'(pzc_ff) - 44'(pxs_ff));
      x1_3_in = x1_wide[27:0];
      z1_in   = z1_wide[27:0];
      z1s_in  = 42'(z1_ff) * 42'(sp_ff);
      z1c_in  = 42'(z1_ff) * 42'(cp_ff);
      y2_wide = scale_down(44'(ryc4_ff) - 44'(z1s_ff));
      z2_wide = scale_down(44'(rys4_ff) + 44'(z1c_ff));
      y2_in   = y2_wide[30:0];
      z2_in   = z2_wide[30:0];
      // near depth is at least one, so this also rejects depth at or below zero
      vis     = (z2_ff >= NEAR_DEPTH) && (z2_ff <= FAR_DEPTH);
      item_in.visible = vis;
      item_in.num_x   = vis ? NUM_W'(x1_5_ff) * NUM_W'(FOCAL) : '0;
      item_in.num_y   = vis ? NUM_W'(y2_ff) * NUM_W'(FOCAL) : '0;
      item_in.depth   = vis ? z2_ff[DEPTH_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         rz_ff   <= rz_in;
         pxc_ff  <= pxc_in;
         pzs_ff  <= pzs_in;
         pzc_ff  <= pzc_in;
         pxs_ff  <= pxs_in;
         ryc2_ff <= ryc2_in;
         rys2_ff <= rys2_in;
         x1_3_ff <= x1_3_in;
         z1_ff   <= z1_in;
         ryc3_ff <= ryc2_ff;
         rys3_ff <= rys2_ff;
         z1s_ff  <= z1s_in;
         z1c_ff  <= z1c_in;
         x1_4_ff <= x1_3_ff;
         ryc4_ff <= ryc3_ff;
         rys4_ff <= rys3_ff;
         y2_ff   <= y2_in;
         z2_ff   <= z2_in;
         x1_5_ff <= x1_4_ff;
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/cpp_div.sv
// ----------------------------------------------------------------------------
// cpp div
// pipelined signed divider, several quotient bits per stage, truncating
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_div #(
   parameter int NW   = 40,
   parameter int DW   = 16,
   parameter int STEP = 4
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [NW-1:0] num,
   input  logic        [DW-1:0] den,
   output logic signed [NW:0]   quo
);
   localparam int STAGES = NW / STEP;

   logic [DW-1:0] rem_ff [STAGES+1];
   logic [NW-1:0] acc_ff [STAGES+1];
   logic [DW-1:0] den_ff [STAGES+1];
   logic          neg_ff [STAGES+1];
   logic signed [NW:0] quo_ff, quo_in;

   // magnitude of the numerator, sign kept aside
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= '0;
         acc_ff[0] <= num[NW-1] ? NW'(-num) : NW'(num);
         den_ff[0] <= den;
         neg_ff[0] <= num[NW-1];
      end
   end

   for (genvar s = 1; s <= STAGES; s++) begin : g_stage
      logic [DW-1:0] rem_in;
      logic [NW-1:0] acc_in;

      // restoring steps: acc shifts dividend bits out and quotient bits in
      always_comb begin
         logic [DW:0] t;
         rem_in = rem_ff[s-1];
         acc_in = acc_ff[s-1];
         for (int k = 0; k < STEP; k++) begin
            t      = {rem_in, acc_in[NW-1]};
            acc_in = {acc_in[NW-2:0], 1'b0};
            if (t >= {1'b0, den_ff[s-1]}) begin
               t         = t - {1'b0, den_ff[s-1]};
               acc_in[0] = 1'b1;
            end
            rem_in = t[DW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_in;
            acc_ff[s] <= acc_in;
            den_ff[s] <= den_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
         end
      end
   end

   assign quo_in = neg_ff[STAGES] ? -$signed({1'b0, acc_ff[STAGES]})
                                  : $signed({1'b0, acc_ff[STAGES]});

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff <= quo_in;
      end
   end

   assign quo = quo_ff;

endmodule

`default_nettype wire

>>> hw/rtl/cpp_back.sv
// ----------------------------------------------------------------------------
// cpp back
// perspective divide, screen centring and saturation of queued requests
// ----------------------------------------------------------------------------
`default_nettype none

module cpp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  cpp_pkg::cpp_item_type   q_item,
   output logic                    q_pop,
   output logic                    out_push,
   output cpp_pkg::cpp_result_type out_result,
   input  logic                    out_full
);
   import cpp_pkg::*;

   logic                 en;
   logic [DIV_LAT-1:0]   side_v_ff, side_v_in;
   logic                 side_vis_ff   [DIV_LAT];
   logic [DEPTH_W-1:0]   side_depth_ff [DIV_LAT];
   logic signed [NUM_W:0] qx, qy;
   logic                 fin_v_ff;
   cpp_result_type       fin_ff, fin_in;

   assign en        = !(fin_v_ff && out_full);
   assign q_pop     = en && !q_empty;
   assign out_push  = fin_v_ff && !out_full;
   assign out_result = fin_ff;
   assign side_v_in = {side_v_ff[DIV_LAT-2:0], q_pop};

   cpp_div #(
      .NW   (NUM_W),
      .DW   (DEPTH_W),
      .STEP (DIV_STEP)
   ) u_div_x (
      .clock (clock),
      .en    (en),
      .num   (q_item.num_x),
      .den   (q_item.depth),
      .quo   (qx)
   );

   cpp_div #(
      .NW   (NUM_W),
      .DW   (DEPTH_W),
      .STEP (DIV_STEP)
   ) u_div_y (
      .clock (clock),
      .en    (en),
      .num   (q_item.num_y),
      .den   (q_item.depth),
      .quo   (qy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         side_v_ff <= '0;
         fin_v_ff  <= 1'b0;
      end else if (en) begin
         side_v_ff <= side_v_in;
         fin_v_ff  <= side_v_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_vis_ff[0]   <= q_item.visible;
         side_depth_ff[0] <= q_item.depth;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_vis_ff[i]   <= side_vis_ff[i-1];
            side_depth_ff[i] <= side_depth_ff[i-1];
         end
         fin_ff <= fin_in;
      end
   end

   always_comb begin
      fin_in.visible  = side_vis_ff[DIV_LAT-1];
      fin_in.screen_x = '0;
      fin_in.screen_y = '0;
      fin_in.depth    = '0;
      if (side_vis_ff[DIV_LAT-1]) begin
         fin_in.screen_x = sat16(42'(HALF_WIDTH) + 42'(qx));
         fin_in.screen_y = sat16(42'(HALF_HEIGHT) - 42'(qy));
         fin_in.depth    = side_depth_ff[DIV_LAT-1];
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/camera_point_projector.sv
// an accepted request passes the front pipe, the middle queue, the back divide and the output queue to the rsp ports
// throughput: one request per cycle while full is low; rotation and both divider pipes take one per unstalled cycle
// the divide runs four quotient bits per stage over ten stages for each screen axis
// reset: synchronous, active high; clears both queues and all pipe valid bits,
// loads the camera at the origin with zero yaw and pitch
// ----------------------------------------------------------------------------
// camera point projector
// world point to screen projection with front transform, queue and back divide
// ----------------------------------------------------------------------------
`default_nettype none

module camera_point_projector #(
   parameter int QUEUE_DEPTH = cpp_pkg::QUEUE_DEPTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push,
   output logic                                   full,
   input  logic signed [cpp_pkg::COORD_W-1:0]     req_point_x,
   input  logic signed [cpp_pkg::COORD_W-1:0]     req_point_y,
   input  logic signed [cpp_pkg::COORD_W-1:0]     req_point_z,
   output logic                                   empty,
   input  logic                                   pop,
   output logic                                   rsp_visible,
   output logic signed [cpp_pkg::PIXEL_W-1:0]     rsp_screen_x,
   output logic signed [cpp_pkg::PIXEL_W-1:0]     rsp_screen_y,
   output logic        [cpp_pkg::DEPTH_W-1:0]     rsp_depth,
   input  logic                                   csr_we,
   input  logic        [cpp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic        [cpp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cpp_pkg::*;

   localparam int ITEM_W = $bits(cpp_item_type);
   localparam int RES_W  = $bits(cpp_result_type);

   logic           mid_push, mid_full, mid_pop, mid_empty;
   cpp_item_type   front_item, back_item;
   logic [ITEM_W-1:0] mid_rdata;
   logic           out_push, out_full;
   cpp_result_type back_result, rsp_result;
   logic [RES_W-1:0] out_rdata;

   cpp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .req_point_z (req_point_z),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .q_push      (mid_push),
      .q_item      (front_item),
      .q_full      (mid_full)
   );

   cpp_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (front_item),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   assign back_item = cpp_item_type'(mid_rdata);

   cpp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (mid_empty),
      .q_item     (back_item),
      .q_pop      (mid_pop),
      .out_push   (out_push),
      .out_result (back_result),
      .out_full   (out_full)
   );

   cpp_fifo #(
      .WIDTH (RES_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (out_push),
      .wdata (back_result),
      .full  (out_full),
      .pop   (pop),
      .rdata (out_rdata),
      .empty (empty)
   );

   assign rsp_result   = cpp_result_type'(out_rdata);
   assign rsp_visible  = rsp_result.visible;
   assign rsp_screen_x = rsp_result.screen_x;
   assign rsp_screen_y = rsp_result.screen_y;
   assign rsp_depth    = rsp_result.depth;

endmodule

`default_nettype wire

>>> hw/rtl/cpp_checker.sv
// ----------------------------------------------------------------------------
// cpp checker
// port-level checks of the projector, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "camera_point_projector_macros.svh"

module cpp_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   full,
   input logic                                   empty,
   input logic                                   pop,
   input logic                                   rsp_visible,
   input logic signed [cpp_pkg::PIXEL_W-1:0]     rsp_screen_x,
   input logic signed [cpp_pkg::PIXEL_W-1:0]     rsp_screen_y,
   input logic        [cpp_pkg::DEPTH_W-1:0]     rsp_depth
);
   import cpp_pkg::*;

   // nothing in flight and room for a request once reset is taken
   `CPP_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> empty && !full)

   // a clipped point carries no screen position or depth
   `CPP_ASSERT(a_hidden_zero, clock, reset, !empty && !rsp_visible |-> rsp_screen_x == 16'sd0 && rsp_screen_y == 16'sd0 && rsp_depth == '0)

   // a shown point lies on or beyond the near plane
   `CPP_ASSERT(a_visible_depth, clock, reset, !empty && rsp_visible |-> rsp_depth >= DEPTH_W'(NEAR_DEPTH))

   // a waiting result holds until taken
   `CPP_ASSERT(a_result_holds, clock, reset, !empty && !pop |=> !empty && $stable(rsp_visible) && $stable(rsp_screen_x) && $stable(rsp_screen_y) && $stable(rsp_depth))

endmodule

bind camera_point_projector cpp_checker u_checker (.*);

`default_nettype wire

>>> tb/sv/projection_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// projection checker
// watches the request, result and register ports of the point projector,
// predicts each projection in wide signed arithmetic and compares in order
// ----------------------------------------------------------------------------
`default_nettype none

module projection_checker (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   push,
   input  wire logic                                   full,
   input  wire logic signed [cpp_pkg::COORD_W-1:0]     req_point_x,
   input  wire logic signed [cpp_pkg::COORD_W-1:0]     req_point_y,
   input  wire logic signed [cpp_pkg::COORD_W-1:0]     req_point_z,
   input  wire logic                                   empty,
   input  wire logic                                   pop,
   input  wire logic                                   rsp_visible,
   input  wire logic signed [cpp_pkg::PIXEL_W-1:0]     rsp_screen_x,
   input  wire logic signed [cpp_pkg::PIXEL_W-1:0]     rsp_screen_y,
   input  wire logic        [cpp_pkg::DEPTH_W-1:0]     rsp_depth,
   input  wire logic                                   csr_we,
   input  wire logic        [cpp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic        [cpp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                          fail_count,
   output int                                          pending_count,
   output int                                          result_count,
   output int                                          visible_count
);
   import cpp_pkg::*;

   longint cam_x, cam_y, cam_z, sin_yaw, cos_yaw, sin_pitch, cos_pitch;
   cpp_result_type projection_queue[$];

   function automatic longint quot(input longint a, input longint b);
      longint q;
      q = (a < 0 ? -a : a) / (b < 0 ? -b : b);
      return ((a < 0) != (b < 0)) ? -q : q;
   endfunction

   function automatic logic signed [PIXEL_W-1:0] clip16(input longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[PIXEL_W-1:0];
   endfunction

   function automatic cpp_result_type project_point(input longint px, input longint py,
                                                    input longint pz);
      cpp_result_type r;
      longint rx, ry, rz, x1, z1, y2, z2;
      rx = px - cam_x;
      ry = py - cam_y;
      rz = pz - cam_z;
      x1 = quot(rx * cos_yaw + rz * sin_yaw, FIXED_SCALE);
      z1 = quot(rz * cos_yaw - rx * sin_yaw, FIXED_SCALE);
      y2 = quot(ry * cos_pitch - z1 * sin_pitch, FIXED_SCALE);
      z2 = quot(ry * sin_pitch + z1 * cos_pitch, FIXED_SCALE);
      r = '0;
      if (z2 >= NEAR_DEPTH && z2 <= FAR_DEPTH) begin
         r.visible  = 1'b1;
         r.screen_x = clip16(HALF_WIDTH + quot(x1 * FOCAL, z2));
         r.screen_y = clip16(HALF_HEIGHT - quot(y2 * FOCAL, z2));
         r.depth    = z2[DEPTH_W-1:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch on result %0d: %s got %0d expected %0d", result_count, what, got,
               want);
      fail_count++;
   endtask

   assign pending_count = projection_queue.size();

   always @(posedge clock) begin
      cpp_result_type want;
      if (reset) begin
         cam_x = 0; cam_y = 0; cam_z = 0;
         sin_yaw = 0; cos_yaw = 4096; sin_pitch = 0; cos_pitch = 4096;
         projection_queue.delete();
         fail_count = 0;
         result_count = 0;
         visible_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CAM_X:       cam_x     = longint'($signed(csr_wdata[23:0]));
               CSR_CAM_Y:       cam_y     = longint'($signed(csr_wdata[23:0]));
               CSR_CAM_Z:       cam_z     = longint'($signed(csr_wdata[23:0]));
               CSR_SIN_NEG_YAW: sin_yaw   = longint'($signed(csr_wdata[13:0]));
               CSR_COS_NEG_YAW: cos_yaw   = longint'($signed(csr_wdata[13:0]));
               CSR_SIN_PITCH:   sin_pitch = longint'($signed(csr_wdata[13:0]));
               CSR_COS_PITCH:   cos_pitch = longint'($signed(csr_wdata[13:0]));
               default: ;
            endcase
         end
         if (pop && !empty) begin
            if (projection_queue.size() == 0) begin
               report_mismatch("unexpected request result", 1, 0);
            end else begin
               want = projection_queue.pop_front();
               if (rsp_visible !== want.visible)
                  report_mismatch("visible", rsp_visible, want.visible);
               if (rsp_screen_x !== want.screen_x)
                  report_mismatch("screen_x", rsp_screen_x, want.screen_x);
               if (rsp_screen_y !== want.screen_y)
                  report_mismatch("screen_y", rsp_screen_y, want.screen_y);
               if (rsp_depth !== want.depth)
                  report_mismatch("depth", rsp_depth, want.depth);
               if (want.visible) visible_count++;
            end
            result_count++;
         end
         if (push && !full)
            projection_queue.push_back(project_point(req_point_x, req_point_y, req_point_z));
      end
   end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point projector testbench
// drives directed and random points through several camera settings with
// random gaps on both sides; the checker predicts and compares each result
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
   import cpp_pkg::*;

   // register index with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   logic clock, reset, push, full, empty, pop, csr_we;
   logic signed [COORD_W-1:0] req_point_x, req_point_y, req_point_z;
   logic rsp_visible;
   logic signed [PIXEL_W-1:0] rsp_screen_x, rsp_screen_y;
   logic [DEPTH_W-1:0] rsp_depth;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int fail_count, pending_count, result_count, visible_count;
   int request_count;
   bit hold_results;

   camera_point_projector u_top (.*);
   projection_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("timeout waiting for results");
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic int gap_length();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // result side: random stalls, held off entirely while hold_results is set
   initial begin
      pop = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_results) pop <= 1'b0;
         else if ($urandom_range(0, 9) < 7) pop <= 1'b1;
         else pop <= ($urandom_range(0, 29) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input longint value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_camera(input longint cx, input longint cy, input longint cz,
                             input longint sy, input longint cyw, input longint sp,
                             input longint cp);
      write_csr(CSR_CAM_X, cx);
      write_csr(CSR_CAM_Y, cy);
      write_csr(CSR_CAM_Z, cz);
      write_csr(CSR_SIN_NEG_YAW, sy);
      write_csr(CSR_COS_NEG_YAW, cyw);
      write_csr(CSR_SIN_PITCH, sp);
      write_csr(CSR_COS_PITCH, cp);
   endtask

   // sender: gap is taken before the item so push stays high across back-to-back items
   task automatic send_point(input longint px, input longint py, input longint pz,
                             input bit with_gap);
      int gap;
      gap = with_gap ? gap_length() : 0;
      if (gap > 0) begin
         @(negedge clock);
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end else begin
         @(negedge clock);
      end
      push <= 1'b1;
      req_point_x <= px[COORD_W-1:0];
      req_point_y <= py[COORD_W-1:0];
      req_point_z <= pz[COORD_W-1:0];
      @(posedge clock);
      while (full) @(posedge clock);
      request_count++;
   endtask

   task automatic drain();
      @(negedge clock);
      push <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   function automatic longint rand_coord();
      case ($urandom_range(0, 3))
         0: return longint'($signed(24'($urandom)));
         1: return longint'($urandom_range(0, 4000)) - 2000;
         2: return longint'($urandom_range(0, 200000)) - 100000;
         default: return longint'($urandom_range(0, 60000)) - 30000;
      endcase
   endfunction

   // mostly points in front of the camera so the divide path is exercised
   task automatic random_points(input int count);
      longint cz;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 3) != 0) cz = $urandom_range(10, 70000);
         else cz = rand_coord();
         send_point(rand_coord(), rand_coord(), cz, 1'b1);
      end
   endtask

   initial begin
      int hold;
      longint t;
      reset = 1'b1;
      push = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_point_x = '0;
      req_point_y = '0;
      req_point_z = '0;
      hold_results = 1'b0;
      request_count = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset camera, field extremes, near and far planes, saturation
      send_point(0, 0, 100, 1'b0);
      send_point(0, 0, 16, 1'b0);
      send_point(0, 0, 15, 1'b0);
      send_point(0, 0, 65535, 1'b0);
      send_point(0, 0, 65536, 1'b0);
      send_point(0, 0, 0, 1'b0);
      send_point(0, 0, -100, 1'b0);
      send_point(8388607, 8388607, 16, 1'b0);
      send_point(-8388608, -8388608, 16, 1'b0);
      send_point(8388607, -8388608, 8388607, 1'b0);
      send_point(-8388608, 8388607, -8388608, 1'b0);
      send_point(-1, -1, 17, 1'b0);
      send_point(1000, -1000, 20, 1'b0);
      drain();

      set_camera(8388607, -8388608, -8388608, 4096, -4096, -4096, 4096);
      send_point(8388607, 0, 0, 1'b0);
      send_point(-8388608, 8388607, 100, 1'b0);
      drain();
      // trig outside unit range, an ignored register index
      set_camera(-8388608, 8388607, 8388607, 8191, -8192, -8192, 8191);
      write_csr(CSR_SPARE, 24'hffffff);
      send_point(-8388608, -8388608, -8388608, 1'b0);
      send_point(0, 0, 0, 1'b0);
      drain();
      set_camera(0, 0, 0, 0, 4096, 0, 4096);

      // long result stall while requests keep coming
      fork
         random_points(40);
         begin
            hold_results = 1'b1;
            for (hold = 0; hold < 200; hold++) @(posedge clock);
            hold_results = 1'b0;
         end
      join
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         t = $urandom_range(0, 4096);
         set_camera(rand_coord(), rand_coord(), rand_coord(),
                    longint'($urandom_range(0, 8192)) - 4096,
                    (phase == 0) ? 4096 : longint'($urandom_range(0, 8192)) - 4096,
                    t - 2048, longint'($urandom_range(0, 8192)) - 4096);
         if (phase % 2 == 0) set_camera(0, 0, 0, 0, 4096, 0, 4096);
         random_points(310);
         drain();
      end

      $display("sent %0d requests, checked %0d results, %0d of them visible",
               request_count, result_count, visible_count);
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
